@@ rtl/ab_boot_slot_selector_unit_defines.svh @@
// assertion macros for the boot slot selector
`ifndef AB_BOOT_SLOT_SELECTOR_UNIT_DEFINES_SVH
`define AB_BOOT_SLOT_SELECTOR_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked on every clock edge outside reset
`define ABSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked on every clock edge, reset included
`define ABSS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define ABSS_ASSERT(lbl, prop, msg)
`define ABSS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ rtl/abss_pkg.sv @@
package abss_pkg;

  // operation codes
  localparam logic [1:0] OP_ACTIVATE   = 2'd0;
  localparam logic [1:0] OP_FIND_BOOT  = 2'd1;
  localparam logic [1:0] OP_GET_ACTIVE = 2'd2;
  localparam logic [1:0] OP_MARK_OK    = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_SLOT = 2'd1;
  localparam logic [1:0] ST_NO_TABLE = 2'd2;
  localparam logic [1:0] ST_NONE     = 2'd3;

  // record constants
  localparam logic [3:0] PRI_TOP    = 4'd15;
  localparam logic [3:0] PRI_SECOND = 4'd14;
  localparam logic [2:0] TRIES_MAX  = 3'd7;

  // datapath actions, one per microcode step
  typedef enum logic [3:0] {
    ACT_SET_CHK,
    ACT_SET_LOOP,
    ACT_SET_END,
    ACT_FIND_CHK,
    ACT_FIND_SCAN,
    ACT_FIND_CHKF,
    ACT_FIND_UPD,
    ACT_FIND_END,
    ACT_GET_SCAN,
    ACT_GET_END,
    ACT_MARK
  } act_e;

  // microcode addresses
  localparam logic [3:0] UA_SET_CHK   = 4'd0;
  localparam logic [3:0] UA_SET_LOOP  = 4'd1;
  localparam logic [3:0] UA_SET_END   = 4'd2;
  localparam logic [3:0] UA_FIND_CHK  = 4'd3;
  localparam logic [3:0] UA_FIND_SCAN = 4'd4;
  localparam logic [3:0] UA_FIND_CHKF = 4'd5;
  localparam logic [3:0] UA_FIND_UPD  = 4'd6;
  localparam logic [3:0] UA_FIND_END  = 4'd7;
  localparam logic [3:0] UA_GET_SCAN  = 4'd8;
  localparam logic [3:0] UA_GET_END   = 4'd9;
  localparam logic [3:0] UA_MARK      = 4'd10;

  // one control word: action, repeat over all slots, last step of the program
  typedef struct packed {
    act_e act;
    logic loop;
    logic fin;
  } uword_t;

  // control from sequencer to datapath
  typedef struct packed {
    act_e act;
    logic run;
    logic fin;
  } ctrl_t;

  function automatic uword_t ucode_rom(input logic [3:0] addr);
    uword_t w;
    unique case (addr)
      UA_SET_CHK:   w = '{act: ACT_SET_CHK,   loop: 1'b0, fin: 1'b0};
      UA_SET_LOOP:  w = '{act: ACT_SET_LOOP,  loop: 1'b1, fin: 1'b0};
      UA_SET_END:   w = '{act: ACT_SET_END,   loop: 1'b0, fin: 1'b1};
      UA_FIND_CHK:  w = '{act: ACT_FIND_CHK,  loop: 1'b0, fin: 1'b0};
      UA_FIND_SCAN: w = '{act: ACT_FIND_SCAN, loop: 1'b1, fin: 1'b0};
      UA_FIND_CHKF: w = '{act: ACT_FIND_CHKF, loop: 1'b0, fin: 1'b0};
      UA_FIND_UPD:  w = '{act: ACT_FIND_UPD,  loop: 1'b1, fin: 1'b0};
      UA_FIND_END:  w = '{act: ACT_FIND_END,  loop: 1'b0, fin: 1'b1};
      UA_GET_SCAN:  w = '{act: ACT_GET_SCAN,  loop: 1'b1, fin: 1'b0};
      UA_GET_END:   w = '{act: ACT_GET_END,   loop: 1'b0, fin: 1'b1};
      UA_MARK:      w = '{act: ACT_MARK,      loop: 1'b0, fin: 1'b1};
      default:      w = '{act: ACT_MARK,      loop: 1'b0, fin: 1'b1};
    endcase
    return w;
  endfunction

  function automatic logic [3:0] ucode_entry(input logic [1:0] op);
    logic [3:0] a;
    unique case (op)
      OP_ACTIVATE:   a = UA_SET_CHK;
      OP_FIND_BOOT:  a = UA_FIND_CHK;
      OP_GET_ACTIVE: a = UA_GET_SCAN;
      OP_MARK_OK:    a = UA_MARK;
      default:       a = UA_MARK;
    endcase
    return a;
  endfunction

endpackage

@@ rtl/abss_seq.sv @@
module abss_seq #(
  parameter int SLOT_COUNT = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [1:0]                    op_i,
  input  logic                          hold_i,
  input  logic                          fail_i,
  output abss_pkg::ctrl_t               ctrl_o,
  output logic [$clog2(SLOT_COUNT)-1:0] ptr_o,
  output logic                          busy_o
);

  localparam int PtrW = $clog2(SLOT_COUNT);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(SLOT_COUNT - 1);

  logic [3:0]      upc_q, upc_d;
  logic [PtrW-1:0] ptr_q, ptr_d;
  logic            busy_q, busy_d;
  abss_pkg::uword_t word;
  logic            ends;
  logic            run;

  // current control word
  assign word = abss_pkg::ucode_rom(upc_q);
  assign ends = fail_i || word.fin;
  assign run  = busy_q && !(ends && hold_i);

  assign ctrl_o = '{act: word.act, run: run, fin: word.fin};
  assign ptr_o  = ptr_q;
  assign busy_o = busy_q;

  // step counter and slot pointer
  always_comb begin
    upc_d  = upc_q;
    ptr_d  = ptr_q;
    busy_d = busy_q;
    if (start_i) begin
      busy_d = 1'b1;
      upc_d  = abss_pkg::ucode_entry(op_i);
      ptr_d  = '0;
    end else if (run) begin
      if (ends) begin
        busy_d = 1'b0;
      end else if (word.loop && ptr_q != PtrLast) begin
        ptr_d = ptr_q + 1'b1;
      end else begin
        upc_d = upc_q + 4'd1;
        ptr_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q  <= abss_pkg::UA_SET_CHK;
      ptr_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      upc_q  <= upc_d;
      ptr_q  <= ptr_d;
      busy_q <= busy_d;
    end
  end

endmodule

@@ rtl/ab_boot_slot_selector_unit.sv @@
// channel  direction  handshake                 payload
// in       input      in_valid_i / in_stall_o   operation_i, slot_index_i, signature_ok_i
// out      output     out_valid_o / out_stall_i status_o, chosen_slot_o
//
// one command at a time, one slot record per cycle; reset clears every record at once
// activate checks the slot, writes every record and sets the table valid; find_boot checks the table,
// scans every record, checks the pick and updates the records; get_active scans every record
// a failed check ends the program early with bad slot, no table or no pick
// a new command is taken while the last result still waits
// a program stalls on its final step until the output register is free
`include "ab_boot_slot_selector_unit_defines.svh"

module ab_boot_slot_selector_unit #(
  parameter int SLOT_COUNT = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] operation_i,
  input  logic [2:0] slot_index_i,
  input  logic [7:0] signature_ok_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] status_o,
  output logic [2:0] chosen_slot_o
);

  localparam int PtrW = $clog2(SLOT_COUNT);

  // slot table
  logic                  tv_q;
  logic [SLOT_COUNT-1:0] boot_q;
  logic [SLOT_COUNT-1:0] succ_q;
  logic [3:0]            pri_q   [SLOT_COUNT];
  logic [2:0]            tries_q [SLOT_COUNT];

  // command and search registers
  logic [2:0]            slot_q;
  logic [SLOT_COUNT-1:0] sig_q;
  logic                  found_q, found_d;
  logic [PtrW-1:0]       best_q, best_d;
  logic [3:0]            best_pri_q, best_pri_d;

  // result register
  logic       out_valid_q;
  logic [1:0] status_q, status_d;
  logic [2:0] chosen_q, chosen_d;

  abss_pkg::ctrl_t ctrl;
  logic [PtrW-1:0] ptr;
  logic            busy;
  logic            hold;
  logic            in_xfer;
  logic            out_xfer;
  logic            fail;
  logic [1:0]      fail_status;
  logic            res_load;

  // record at the pointer
  logic       cur_boot;
  logic       cur_succ;
  logic [3:0] cur_pri;
  logic [2:0] cur_tries;
  logic       slot_ok;
  logic       ptr_is_slot;
  logic       qual;

  // table writes
  logic            tv_set;
  logic [PtrW-1:0] w_idx;
  logic            boot_we, succ_we, pri_we, tries_we;
  logic            boot_wd, succ_wd;
  logic [3:0]      pri_wd;
  logic [2:0]      tries_wd;

  assign in_stall_o = busy;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_xfer   = out_valid_q && !out_stall_i;
  assign hold       = out_valid_q && out_stall_i;

  abss_seq #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(in_xfer),
    .op_i   (operation_i),
    .hold_i (hold),
    .fail_i (fail),
    .ctrl_o (ctrl),
    .ptr_o  (ptr),
    .busy_o (busy)
  );

  // record read and per-slot tests
  assign cur_boot    = boot_q[ptr];
  assign cur_succ    = succ_q[ptr];
  assign cur_pri     = pri_q[ptr];
  assign cur_tries   = tries_q[ptr];
  assign slot_ok     = {1'b0, slot_q} < 4'(SLOT_COUNT);
  assign ptr_is_slot = 3'(ptr) == slot_q;
  assign qual        = (cur_pri != 4'd0) &&
                       (cur_succ || (cur_tries != 3'd0 && sig_q[ptr]));

  // early exits
  always_comb begin
    fail        = 1'b0;
    fail_status = abss_pkg::ST_OK;
    unique case (ctrl.act)
      abss_pkg::ACT_SET_CHK: begin
        fail        = !slot_ok;
        fail_status = abss_pkg::ST_BAD_SLOT;
      end
      abss_pkg::ACT_FIND_CHK: begin
        fail        = !tv_q;
        fail_status = abss_pkg::ST_NO_TABLE;
      end
      abss_pkg::ACT_FIND_CHKF, abss_pkg::ACT_GET_END: begin
        fail        = !found_q;
        fail_status = abss_pkg::ST_NONE;
      end
      abss_pkg::ACT_MARK: begin
        fail        = !slot_ok || !tv_q;
        fail_status = !slot_ok ? abss_pkg::ST_BAD_SLOT : abss_pkg::ST_NO_TABLE;
      end
      default: begin
        fail        = 1'b0;
        fail_status = abss_pkg::ST_OK;
      end
    endcase
  end

  // search state and table updates per step
  always_comb begin
    found_d    = found_q;
    best_d     = best_q;
    best_pri_d = best_pri_q;
    tv_set     = 1'b0;
    w_idx      = ptr;
    boot_we    = 1'b0;
    succ_we    = 1'b0;
    pri_we     = 1'b0;
    tries_we   = 1'b0;
    boot_wd    = 1'b0;
    succ_wd    = 1'b0;
    pri_wd     = 4'd0;
    tries_wd   = 3'd0;
    if (in_xfer) begin
      found_d = 1'b0;
    end else if (ctrl.run) begin
      unique case (ctrl.act)
        abss_pkg::ACT_SET_LOOP: begin
          if (ptr_is_slot) begin
            {boot_we, succ_we, pri_we, tries_we} = 4'b1111;
            boot_wd  = 1'b1;
            pri_wd   = abss_pkg::PRI_TOP;
            tries_wd = abss_pkg::TRIES_MAX;
          end else if (!tv_q) begin
            {boot_we, succ_we, pri_we, tries_we} = 4'b1111;
          end else if (cur_pri == abss_pkg::PRI_TOP) begin
            pri_we = 1'b1;
            pri_wd = abss_pkg::PRI_SECOND;
          end
        end
        abss_pkg::ACT_SET_END: begin
          tv_set = 1'b1;
        end
        abss_pkg::ACT_FIND_SCAN: begin
          // ascending scan with >= keeps ties on the higher index
          if (qual && (!found_q || cur_pri >= best_pri_q)) begin
            found_d    = 1'b1;
            best_d     = ptr;
            best_pri_d = cur_pri;
          end
        end
        abss_pkg::ACT_FIND_UPD: begin
          // slots ranked ahead of the pick all failed: zero their priority
          if (ptr == best_q) begin
            if (!cur_succ) begin
              tries_we = 1'b1;
              tries_wd = cur_tries - 3'd1;
            end
          end else if ({cur_pri, ptr} > {best_pri_q, best_q}) begin
            pri_we = 1'b1;
            pri_wd = 4'd0;
          end
        end
        abss_pkg::ACT_GET_SCAN: begin
          if (!found_q && cur_boot && cur_pri == abss_pkg::PRI_TOP) begin
            found_d = 1'b1;
            best_d  = ptr;
          end
        end
        abss_pkg::ACT_MARK: begin
          if (!fail) begin
            w_idx   = slot_q[PtrW-1:0];
            succ_we = 1'b1;
            succ_wd = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // result of the program
  assign res_load = ctrl.run && (fail || ctrl.fin);

  always_comb begin
    status_d = abss_pkg::ST_OK;
    chosen_d = 3'd0;
    if (fail) begin
      status_d = fail_status;
    end else if (ctrl.act == abss_pkg::ACT_SET_END || ctrl.act == abss_pkg::ACT_MARK) begin
      chosen_d = slot_q;
    end else begin
      chosen_d = 3'(best_q);
    end
  end

  // slot table registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tv_q   <= 1'b0;
      boot_q <= '0;
      succ_q <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        pri_q[i]   <= 4'd0;
        tries_q[i] <= 3'd0;
      end
    end else begin
      if (tv_set) begin
        tv_q <= 1'b1;
      end
      if (boot_we) begin
        boot_q[w_idx] <= boot_wd;
      end
      if (succ_we) begin
        succ_q[w_idx] <= succ_wd;
      end
      if (pri_we) begin
        pri_q[w_idx] <= pri_wd;
      end
      if (tries_we) begin
        tries_q[w_idx] <= tries_wd;
      end
    end
  end

  // command capture and search registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      slot_q <= slot_index_i;
      sig_q  <= signature_ok_i[SLOT_COUNT-1:0];
    end
    best_q     <= best_d;
    best_pri_q <= best_pri_d;
    if (res_load) begin
      status_q <= status_d;
      chosen_q <= chosen_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      found_q <= found_d;
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign chosen_slot_o = chosen_q;

  // checks
  `ABSS_ASSERT(a_result_from_program, $rose(out_valid_q) |-> $past(busy), "result without a command")
  `ABSS_ASSERT(a_idle_after_result, res_load |=> !busy, "sequencer still busy after result")
  `ABSS_ASSERT(a_table_stays_valid, $past(tv_q) |-> tv_q, "table valid flag dropped")
  `ABSS_ASSERT(a_no_load_while_held, res_load |-> !hold, "result overwritten while stalled")
  `ABSS_ASSERT_ALWAYS(a_fail_zero_slot, (res_load && fail) |-> (chosen_d == 3'd0), "failed result names a slot")

endmodule
